// File: rtl/skyl_pkg.sv
// Shared types and constants for the skyline atlas allocator.
// No dependencies; imported by the scan engine, the output register and the top level.
package skyl_pkg;

  localparam int unsigned PAD   = 2;
  localparam int unsigned REQ_W = 8;
  localparam int unsigned POS_W = 8;

  typedef struct packed {
    logic             full_res;
    logic             page;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } skyl_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } skyl_stat_t;

endpackage

// File: rtl/skyline_atlas_allocator_top.sv
// Skyline atlas allocator. Each request runs one backward and one forward sweep
// over the columns of every page tried (when the padded width is below the page
// width), through the single read port of the column memory, and a placement
// adds one write per covered column of the padded width. After reset a clearing
// pass zeroes the column memory, and no request is taken until it ends. A
// finished result waits in an output register while the next request is taken.
// Depends on skyl_pkg, skyl_scan, skyl_ram and skyl_outreg.
module skyline_atlas_allocator_top
  import skyl_pkg::*;
#(
  parameter int unsigned PAGE_WIDTH  = 256,
  parameter int unsigned PAGE_HEIGHT = 256,
  parameter int unsigned PAGE_COUNT  = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_width_i,
  input  logic [REQ_W-1:0] req_height_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             full_res_o,
  output logic             page_o,
  output logic [POS_W-1:0] pos_x_o,
  output logic [POS_W-1:0] pos_y_o
);

  skyl_stat_t stat;
  skyl_res_t  scan_res;
  skyl_res_t  out_res;
  logic       res_take;

  assign in_stall_o = !stat.idle;

  skyl_scan #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && stat.idle),
    .req_width_i  (req_width_i),
    .req_height_i (req_height_i),
    .res_take_i   (res_take),
    .stat_o       (stat),
    .res_o        (scan_res)
  );

  skyl_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (stat.res_valid),
    .res_i       (scan_res),
    .res_take_o  (res_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign full_res_o = out_res.full_res;
  assign page_o     = out_res.page;
  assign pos_x_o    = out_res.pos_x;
  assign pos_y_o    = out_res.pos_y;

endmodule

// File: rtl/skyl_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module skyl_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/skyl_scan.sv
// Scan engine: column fill memory, window-maximum search and fill update.
// Depends on skyl_pkg and skyl_ram (column store and per-page suffix maxima).
module skyl_scan
  import skyl_pkg::*;
#(
  parameter int unsigned PAGE_WIDTH  = 256,
  parameter int unsigned PAGE_HEIGHT = 256,
  parameter int unsigned PAGE_COUNT  = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REQ_W-1:0] req_width_i,
  input  logic [REQ_W-1:0] req_height_i,
  input  logic             res_take_i,
  output skyl_stat_t       stat_o,
  output skyl_res_t        res_o
);

  localparam int unsigned DEPTH = PAGE_COUNT * PAGE_WIDTH;
  localparam int unsigned XW    = $clog2(PAGE_WIDTH);
  localparam int unsigned CAW   = $clog2(DEPTH);
  localparam int unsigned HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int unsigned PGW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned WW    = REQ_W + 1;
  localparam int unsigned CW    = ((XW > WW) ? XW : WW) + 1;
  localparam int unsigned SW    = ((HW > WW) ? HW : WW) + 1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_PAGE   = 9'b000000100,
    ST_BWD    = 9'b000001000,
    ST_FWD    = 9'b000010000,
    ST_DRAIN  = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_WRITE  = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CAW-1:0]  clr_q, clr_d;
  logic [CAW-1:0]  base_q, base_d;
  logic [PGW-1:0]  page_q, page_d;
  logic [XW-1:0]   ja_q, ja_d;
  logic [WW-1:0]   w_q, w_d;
  logic [WW-1:0]   h_q, h_d;
  logic [HW-1:0]   best_q, best_d;
  logic [XW-1:0]   bx_q, bx_d;
  logic [WW-1:0]   c_q, c_d;
  logic [HW-1:0]   s_q, s_d;
  logic [HW-1:0]   p_q, p_d;
  logic            full_q, full_d;
  logic            pv_q, pv_d;
  logic            pfw_q, pfw_d;
  logic [XW-1:0]   pj_q, pj_d;

  logic            col_we;
  logic [CAW-1:0]  col_wa, col_ra;
  logic [HW-1:0]   col_wd, col_rd;
  logic            sfx_we;
  logic [XW-1:0]   sfx_wa, sfx_ra;
  logic [HW-1:0]   sfx_wd, sfx_rd;

  logic [SW-1:0]   fill_sum;
  logic            fits;
  logic [HW-1:0]   s_n, p_n, m_n;
  logic            blk_start;
  logic [CW-1:0]   bx_p1;
  logic [SW-1:0]   y_p1;

  assign fill_sum = SW'(best_q) + SW'(h_q);
  assign fits     = fill_sum <= SW'(PAGE_HEIGHT);

  skyl_ram #(.DEPTH(DEPTH), .WIDTH(HW)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_wa),
    .wdata_i (col_wd),
    .raddr_i (col_ra),
    .rdata_o (col_rd)
  );

  skyl_ram #(.DEPTH(PAGE_WIDTH), .WIDTH(HW)) u_sfx_ram (
    .clk_i   (clk_i),
    .we_i    (sfx_we),
    .waddr_i (sfx_wa),
    .wdata_i (sfx_wd),
    .raddr_i (sfx_ra),
    .rdata_o (sfx_rd)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    base_d  = base_q;
    page_d  = page_q;
    ja_d    = ja_q;
    w_d     = w_q;
    h_d     = h_q;
    best_d  = best_q;
    bx_d    = bx_q;
    c_d     = c_q;
    s_d     = s_q;
    p_d     = p_q;
    full_d  = full_q;
    pv_d    = 1'b0;
    pfw_d   = 1'b0;
    pj_d    = ja_q;
    col_we  = 1'b0;
    col_wa  = base_q + CAW'(bx_q) + CAW'(ja_q);
    col_wd  = fill_sum[HW-1:0];
    col_ra  = base_q + CAW'(ja_q);
    sfx_we  = 1'b0;
    sfx_wa  = pj_q;
    sfx_ra  = ja_q - XW'(w_q) + XW'(1);
    s_n     = s_q;
    p_n     = p_q;
    m_n     = p_q;
    blk_start = 1'b0;
    sfx_wd  = s_q;

    unique case (state_q)
      ST_CLEAR: begin
        col_we = 1'b1;
        col_wa = clr_q;
        col_wd = '0;
        clr_d  = clr_q + CAW'(1);
        if (clr_q == CAW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          w_d     = WW'(req_width_i) + WW'(PAD);
          h_d     = WW'(req_height_i) + WW'(PAD);
          page_d  = '0;
          base_d  = '0;
          full_d  = 1'b0;
          state_d = ST_PAGE;
        end
      end
      ST_PAGE: begin
        best_d = HW'(PAGE_HEIGHT);
        bx_d   = '0;
        ja_d   = XW'(PAGE_WIDTH - 1);
        c_d    = '0;
        // A window only exists when the padded width is below the page width
        if (CW'(w_q) < CW'(PAGE_WIDTH)) begin
          state_d = ST_BWD;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_BWD: begin
        pv_d = 1'b1;
        if (ja_q == '0) begin
          state_d = ST_FWD;
        end else begin
          ja_d = ja_q - XW'(1);
        end
      end
      ST_FWD: begin
        pv_d  = 1'b1;
        pfw_d = 1'b1;
        if (ja_q == XW'(PAGE_WIDTH - 2)) begin
          state_d = ST_DRAIN;
        end else begin
          ja_d = ja_q + XW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (fits) begin
          ja_d    = '0;
          state_d = ST_WRITE;
        end else if (page_q == PGW'(PAGE_COUNT - 1)) begin
          full_d  = 1'b1;
          state_d = ST_RESULT;
        end else begin
          page_d  = page_q + PGW'(1);
          base_d  = base_q + CAW'(PAGE_WIDTH);
          state_d = ST_PAGE;
        end
      end
      ST_WRITE: begin
        col_we = 1'b1;
        if (CW'(ja_q) + CW'(1) == CW'(w_q)) begin
          state_d = ST_RESULT;
        end else begin
          ja_d = ja_q + XW'(1);
        end
      end
      ST_RESULT: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Process stage: column data arrives in the cycle after the read
    if (pv_q) begin
      if (!pfw_q) begin
        // Backward pass: suffix maxima within blocks aligned to the page end
        s_n    = (c_q == '0) ? col_rd : ((col_rd > s_q) ? col_rd : s_q);
        s_d    = s_n;
        sfx_we = 1'b1;
        sfx_wd = s_n;
        if (pj_q != '0) begin
          c_d = (c_q == w_q - WW'(1)) ? '0 : c_q + WW'(1);
        end
      end else begin
        // Forward pass: prefix maxima, combine with suffix of window start
        blk_start = (c_q == w_q - WW'(1)) || (pj_q == '0);
        p_n = blk_start ? col_rd : ((col_rd > p_q) ? col_rd : p_q);
        p_d = p_n;
        c_d = (c_q == '0) ? w_q - WW'(1) : c_q - WW'(1);
        m_n = (sfx_rd > p_n) ? sfx_rd : p_n;
        if (CW'(pj_q) + CW'(1) >= CW'(w_q)) begin
          if (m_n < best_q) begin
            best_d = m_n;
            bx_d   = pj_q - XW'(w_q) + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pv_q    <= 1'b0;
      pfw_q   <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pv_q    <= pv_d;
      pfw_q   <= pfw_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    page_q <= page_d;
    ja_q   <= ja_d;
    w_q    <= w_d;
    h_q    <= h_d;
    best_q <= best_d;
    bx_q   <= bx_d;
    c_q    <= c_d;
    s_q    <= s_d;
    p_q    <= p_d;
    pj_q   <= pj_d;
  end

  assign bx_p1 = CW'(bx_q) + CW'(1);
  assign y_p1  = SW'(best_q) + SW'(1);

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_RESULT);

  assign res_o.full_res = full_q;
  assign res_o.page     = full_q ? 1'b0 : page_q[0];
  assign res_o.pos_x    = full_q ? '0 : bx_p1[POS_W-1:0];
  assign res_o.pos_y    = full_q ? '0 : y_p1[POS_W-1:0];

`ifndef SYNTHESIS
  a_blk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (c_q < w_q))
    else $error("block counter out of range");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("request started while busy");

  a_best_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && pfw_q) |=> (best_q <= $past(best_q)))
    else $error("best height rose during scan");

  a_res_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.res_valid && !full_q) |-> fits)
    else $error("placement exceeds page height");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_we |-> !pv_q)
    else $error("column write during scan");
`endif

endmodule

// File: rtl/skyl_atlas_top_dummy_placeholder.sv
// Result register stage between the scan engine and the output channel.
// Depends on skyl_pkg.
module skyl_outreg
  import skyl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  skyl_res_t res_i,
  output logic      res_take_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output skyl_res_t res_o
);

  logic      out_valid_q, out_valid_d;
  skyl_res_t res_q;

  // Load a new result when the register is empty or its transfer completes
  assign res_take_o  = res_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take_o ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
